// ===== design/pidpc_pkg.sv =====
// pidpc_pkg: widths, register indexes, duty limits and shared types
// for the steering position controller with output clamp. No dependencies.
package pidpc_pkg;

   localparam int POS_W   = 10;
   localparam int GAIN_W  = 16;
   localparam int ERR_W   = POS_W + 1;
   localparam int DELTA_W = ERR_W + 1;
   localparam int SUM_W   = 32;
   localparam int DUTY_W  = 8;
   localparam int IDX_W   = 2;

   localparam int PROD_P_W = GAIN_W + ERR_W;
   localparam int PROD_I_W = GAIN_W + SUM_W;
   localparam int PROD_D_W = GAIN_W + DELTA_W;
   localparam int CMD_W    = PROD_I_W + 1;

   localparam int DUTY_MIN = 65;
   localparam int DUTY_MAX = 245;

   localparam logic [IDX_W-1:0] REG_GAIN_P = 2'd0;
   localparam logic [IDX_W-1:0] REG_GAIN_I = 2'd1;
   localparam logic [IDX_W-1:0] REG_GAIN_D = 2'd2;

   localparam logic signed [GAIN_W-1:0] GAIN_P_RESET = 16'sd1;
   localparam logic signed [GAIN_W-1:0] GAIN_I_RESET = 16'sd0;
   localparam logic signed [GAIN_W-1:0] GAIN_D_RESET = 16'sd0;

   typedef struct packed {
      logic signed [GAIN_W-1:0] prop;
      logic signed [GAIN_W-1:0] integ;
      logic signed [GAIN_W-1:0] deriv;
   } gains_type;

   typedef struct packed {
      logic signed [PROD_P_W-1:0] prop;
      logic signed [PROD_I_W-1:0] integ;
      logic signed [PROD_D_W-1:0] deriv;
   } prod_type;

endpackage

// ===== design/pidpc_step.sv =====
// pidpc_step: error, saturating integral, error change and the three gain
// products, held in the product register. Depends on pidpc_pkg.
module pidpc_step (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   output logic                            in_stall,
   input  logic [pidpc_pkg::POS_W-1:0]     in_setpoint,
   input  logic [pidpc_pkg::POS_W-1:0]     in_measured,
   input  pidpc_pkg::gains_type            gains,
   output logic                            prod_valid,
   input  logic                            prod_stall,
   output pidpc_pkg::prod_type             prod
);
   import pidpc_pkg::*;

   logic                      valid_ff, valid_in;
   prod_type                  prod_ff, prod_in;
   logic signed [SUM_W-1:0]   error_sum_ff, error_sum_in;
   logic signed [ERR_W-1:0]   last_error_ff;
   logic signed [ERR_W-1:0]   err;
   logic signed [DELTA_W-1:0] delta;
   logic signed [SUM_W:0]     sum_wide;
   logic                      take;

   assign in_stall = valid_ff && prod_stall;
   assign take     = in_valid && !in_stall;

   always_comb begin
      err      = $signed({1'b0, in_measured}) - $signed({1'b0, in_setpoint});
      delta    = DELTA_W'(err) - DELTA_W'(last_error_ff);
      sum_wide = (SUM_W + 1)'(error_sum_ff) + (SUM_W + 1)'(err);
      // saturate when the two top bits disagree
      if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
         error_sum_in = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                        : {1'b0, {(SUM_W-1){1'b1}}};
      end else begin
         error_sum_in = sum_wide[SUM_W-1:0];
      end
      prod_in.prop  = PROD_P_W'(gains.prop) * PROD_P_W'(err);
      prod_in.integ = PROD_I_W'(gains.integ) * PROD_I_W'(error_sum_in);
      prod_in.deriv = PROD_D_W'(gains.deriv) * PROD_D_W'(delta);
      valid_in      = in_stall ? valid_ff : in_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= 1'b0;
         error_sum_ff  <= '0;
         last_error_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         if (take) begin
            error_sum_ff  <= error_sum_in;
            last_error_ff <= err;
         end
      end
      if (take) begin
         prod_ff <= prod_in;
      end
   end

   assign prod_valid = valid_ff;
   assign prod       = prod_ff;

   // a non-negative error never lowers the integral
   assert property (@(posedge clock) disable iff (reset)
      (take && !err[ERR_W-1]) |=> (error_sum_ff >= $past(error_sum_ff)))
      else $error("integral fell on a non-negative error");

   // the held error is the one of the last item taken
   assert property (@(posedge clock) disable iff (reset)
      take |=> (last_error_ff == $past(err)))
      else $error("last error not updated");

endmodule

// ===== design/pidpc_clamp.sv =====
// pidpc_clamp: sums the three products, clamps to the duty range and holds
// the result register. Depends on pidpc_pkg.
module pidpc_clamp (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         prod_valid,
   output logic                         prod_stall,
   input  pidpc_pkg::prod_type          prod,
   output logic                         out_valid,
   input  logic                         out_stall,
   output logic [pidpc_pkg::DUTY_W-1:0] out_duty
);
   import pidpc_pkg::*;

   logic                    valid_ff, valid_in;
   logic [DUTY_W-1:0]       duty_ff, duty_in;
   logic signed [CMD_W-1:0] cmd;
   logic                    take;

   assign prod_stall = valid_ff && out_stall;
   assign take       = prod_valid && !prod_stall;

   always_comb begin
      cmd = CMD_W'(prod.prop) + CMD_W'(prod.integ) + CMD_W'(prod.deriv);
      if (cmd < CMD_W'(DUTY_MIN)) begin
         duty_in = DUTY_W'(DUTY_MIN);
      end else if (cmd > CMD_W'(DUTY_MAX)) begin
         duty_in = DUTY_W'(DUTY_MAX);
      end else begin
         duty_in = cmd[DUTY_W-1:0];
      end
      valid_in = prod_stall ? valid_ff : prod_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (take) begin
         duty_ff <= duty_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_duty  = duty_ff;

   // the duty always sits inside the clamp window
   assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (duty_ff >= DUTY_W'(DUTY_MIN) && duty_ff <= DUTY_W'(DUTY_MAX)))
      else $error("duty outside clamp window");

endmodule

// ===== design/pid_position_with_clamp.sv =====
// pid_position_with_clamp: top level of the steering position controller.
// Holds the gain registers and the input register; uses pidpc_pkg,
// pidpc_step and pidpc_clamp.
//
// Each item on the req_ channel is one control step: a setpoint and a
// measured position. Exactly one item leaves on the rsp_ channel for each
// one taken: the PWM duty, clamped to 65..245. An item moves on a rising
// edge with valid high and stall low.
// The pipeline has three registers: input, gain products, result. An item
// passes through them in that order before it shows on rsp_. One item is
// taken every cycle while rsp_stall does not hold the pipeline back; the
// rate is set by the single pass through the products register, with the
// integral and last error updated as each item enters it.
// When rsp_stall is held, the result holds and the pipeline fills; req_stall
// rises once all three registers hold items and falls with rsp_stall.
// Reset clears the integral, the last error and all valid bits, and sets
// the gains to proportional 1, integral 0, derivative 0. Gains are written
// on the csr_ port by index; a write to an unused index does nothing. The
// user must write gains only with no item in flight; the block does not check.
module pid_position_with_clamp (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [pidpc_pkg::POS_W-1:0]         req_setpoint,
   input  logic [pidpc_pkg::POS_W-1:0]         req_measured_position,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [pidpc_pkg::DUTY_W-1:0]        rsp_drive_duty,
   input  logic                                csr_write_enable,
   input  logic [pidpc_pkg::IDX_W-1:0]         csr_index,
   input  logic [pidpc_pkg::GAIN_W-1:0]        csr_write_data
);
   import pidpc_pkg::*;

   gains_type         gains_ff;
   logic              in_valid_ff;
   logic [POS_W-1:0]  setpoint_ff;
   logic [POS_W-1:0]  measured_ff;
   logic              step_stall;
   logic              prod_valid;
   logic              prod_stall;
   prod_type          prod;

   assign req_stall = in_valid_ff && step_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         gains_ff.prop  <= GAIN_P_RESET;
         gains_ff.integ <= GAIN_I_RESET;
         gains_ff.deriv <= GAIN_D_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            REG_GAIN_P: gains_ff.prop  <= $signed(csr_write_data);
            REG_GAIN_I: gains_ff.integ <= $signed(csr_write_data);
            REG_GAIN_D: gains_ff.deriv <= $signed(csr_write_data);
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
      if (req_valid && !req_stall) begin
         setpoint_ff <= req_setpoint;
         measured_ff <= req_measured_position;
      end
   end

   pidpc_step u_step (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (in_valid_ff),
      .in_stall    (step_stall),
      .in_setpoint (setpoint_ff),
      .in_measured (measured_ff),
      .gains       (gains_ff),
      .prod_valid  (prod_valid),
      .prod_stall  (prod_stall),
      .prod        (prod)
   );

   pidpc_clamp u_clamp (
      .clock      (clock),
      .reset      (reset),
      .prod_valid (prod_valid),
      .prod_stall (prod_stall),
      .prod       (prod),
      .out_valid  (rsp_valid),
      .out_stall  (rsp_stall),
      .out_duty   (rsp_drive_duty)
   );

   // gains come out of reset at their defaults
   assert property (@(posedge clock)
      reset |=> (gains_ff.prop == GAIN_P_RESET && gains_ff.integ == GAIN_I_RESET
                 && gains_ff.deriv == GAIN_D_RESET))
      else $error("gains not at reset values");

   // input stalls only while the whole pipeline is full and blocked
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && prod_valid && rsp_valid && rsp_stall))
      else $error("input stalled with room in the pipeline");

endmodule
